/* rtl/core/pcbp_pkg.sv */
// ----------------------------------------------------------------------------
// pcbp_pkg
// Types and constants shared by the prefix-code bit packer.
// ----------------------------------------------------------------------------
package pcbp_pkg;

    localparam int SYMBOLS_DEF      = 256;
    localparam int MAX_CODE_LEN_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int SYMBOL_W = 8;
    localparam int CODE_W   = 32;
    localparam int LEN_IO_W = 6;
    localparam int BYTE_W   = 8;
    localparam int VBITS_W  = 4;
    localparam int TOTAL_W  = 32;

    // Merge window: one accumulator byte plus one full-width code.
    localparam int WORD_W   = BYTE_W + CODE_W;
    // Bytes one encode can complete, plus one for the count itself.
    localparam int BCNT_W   = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FLUSH  = 2'd2
    } action_t;

    // Request handed from the table stage to the packer.
    typedef struct packed {
        logic                flush;
        logic [CODE_W-1:0]   code;
        logic [LEN_IO_W-1:0] len;
    } pcbp_req_t;

endpackage

/* rtl/core/pcbp_cmd_if.sv */
// ----------------------------------------------------------------------------
// pcbp_cmd_if
// Input channel of the packer: load, encode and flush items.
// ----------------------------------------------------------------------------
interface pcbp_cmd_if
    import pcbp_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SYMBOL_W-1:0] symbol;
    logic [CODE_W-1:0]   code_bits;
    logic [LEN_IO_W-1:0] code_length;

    modport source (output valid, action, symbol, code_bits, code_length, input ready);
    modport sink   (input valid, action, symbol, code_bits, code_length, output ready);
endinterface

/* rtl/core/pcbp_res_if.sv */
// ----------------------------------------------------------------------------
// pcbp_res_if
// Output channel of the packer: one packed byte per transfer.
// ----------------------------------------------------------------------------
interface pcbp_res_if
    import pcbp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  packed_byte;
    logic [VBITS_W-1:0] valid_bits;
    logic               last_in_run;
    logic               is_final;
    logic [TOTAL_W-1:0] total_bits;

    modport source (output valid, packed_byte, valid_bits, last_in_run, is_final,
                    total_bits, input ready);
    modport sink   (input valid, packed_byte, valid_bits, last_in_run, is_final,
                    total_bits, output ready);
endinterface

/* rtl/core/pcbp_packer.sv */
// ----------------------------------------------------------------------------
// pcbp_packer
// Merges codes into the byte accumulator and drains completed bytes.
// ----------------------------------------------------------------------------
module pcbp_packer
    import pcbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  pcbp_req_t         req,
    pcbp_res_if.source        res
);

    logic [BYTE_W-1:0]   acc_reg, acc_next;
    logic [2:0]          pend_reg, pend_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [BCNT_W-1:0]   cnt_reg, cnt_next;
    logic                fin_reg, fin_next;
    logic [VBITS_W-1:0]  vbits_reg, vbits_next;
    logic [TOTAL_W-1:0]  ftotal_reg, ftotal_next;

    logic                res_xfer;
    logic                merge;
    logic [CODE_W-1:0]   code_left;
    logic [WORD_W-1:0]   word_merged;
    logic [WORD_W-1:0]   word_rest;
    logic [LEN_IO_W-1:0] nbits;
    logic [TOTAL_W:0]    total_sum;

    assign res_xfer  = res.valid && res.ready;
    assign req_ready = (cnt_reg == '0) || ((cnt_reg == BCNT_W'(1)) && res.ready);
    assign merge     = req_valid && req_ready;

    // Left-align the code, then place it just below the pending bits.
    assign code_left   = req.code << (LEN_IO_W'(CODE_W) - req.len);
    assign word_merged = {acc_reg, {CODE_W{1'b0}}} | ({code_left, {BYTE_W{1'b0}}} >> pend_reg);
    assign nbits       = LEN_IO_W'(pend_reg) + req.len;
    assign word_rest   = word_merged << {nbits[5:3], 3'b000};
    assign total_sum   = {1'b0, total_reg} + (TOTAL_W+1)'(req.len);

    always_comb
    begin
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        total_next  = total_reg;
        word_next   = word_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        vbits_next  = vbits_reg;
        ftotal_next = ftotal_reg;

        if (res_xfer)
        begin
            word_next = word_reg << BYTE_W;
            cnt_next  = cnt_reg - BCNT_W'(1);
        end

        if (merge)
        begin
            if (req.flush)
            begin
                word_next   = {acc_reg, {CODE_W{1'b0}}};
                cnt_next    = BCNT_W'(1);
                fin_next    = 1'b1;
                vbits_next  = VBITS_W'(pend_reg);
                ftotal_next = total_reg;
                acc_next    = '0;
                pend_next   = '0;
                total_next  = '0;
            end
            else
            begin
                word_next   = word_merged;
                cnt_next    = nbits[5:3];
                fin_next    = 1'b0;
                vbits_next  = VBITS_W'(BYTE_W);
                ftotal_next = '0;
                acc_next    = word_rest[WORD_W-1 -: BYTE_W];
                pend_next   = nbits[2:0];
                total_next  = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            pend_reg  <= '0;
            total_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
            total_reg <= total_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        fin_reg    <= fin_next;
        vbits_reg  <= vbits_next;
        ftotal_reg <= ftotal_next;
    end

    assign res.valid       = (cnt_reg != '0);
    assign res.packed_byte = word_reg[WORD_W-1 -: BYTE_W];
    assign res.valid_bits  = vbits_reg;
    assign res.last_in_run = (cnt_reg == BCNT_W'(1));
    assign res.is_final    = fin_reg;
    assign res.total_bits  = ftotal_reg;

endmodule

/* rtl/core/prefix_code_bit_packer_unit.sv */
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_unit
// Table-driven prefix-code emitter with a byte-wide packed output.
// ----------------------------------------------------------------------------
// Path: with the packer idle, an encode or flush transfer passes the table read
//   register, then the merge into the output buffer, before res.valid rises
//   (an encode that completes no byte does not raise it).
// Throughput: one item per cycle while res.ready holds and each item yields at
//   most one byte; an encode completing k bytes (max 4) keeps the packer busy
//   till they drain; the input stalls, paced by the single-byte output channel.
// Reset: control state, accumulator, bit count and the per-symbol loaded
//   flags clear at once; table memory contents stay undefined until loaded.
module prefix_code_bit_packer_unit
    import pcbp_pkg::*;
#(
    parameter int SYMBOLS      = SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    pcbp_cmd_if.sink   cmd,
    pcbp_res_if.source res
);

    // Stored length never exceeds the code field width.
    localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int LEN_W   = $clog2(LEN_CAP + 1);
    localparam int SYM_W   = $clog2(SYMBOLS);
    localparam int ENTRY_W = LEN_W + LEN_CAP;

    // Code table: one entry per symbol holding {length, code}.
    logic [ENTRY_W-1:0] table_mem [SYMBOLS];
    logic [ENTRY_W-1:0] rd_data_reg;

    // Loaded flags stand in for the all-zero length reset.
    logic [SYMBOLS-1:0] loaded_reg, loaded_next;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_flush_reg;
    logic               s1_hit_reg;

    logic               accept;
    logic               in_range;
    logic [SYM_W-1:0]   sym_idx;
    logic [LEN_W-1:0]   len_clamped;
    logic               do_load;
    logic               do_encode;
    logic               do_flush;
    logic               pk_ready;
    pcbp_req_t          pk_req;

    assign accept   = cmd.valid && cmd.ready;
    assign in_range = ({1'b0, cmd.symbol} < (SYMBOL_W+1)'(SYMBOLS));
    assign sym_idx  = cmd.symbol[SYM_W-1:0];

    // Clamp an overlong length to what one entry can hold.
    assign len_clamped = (cmd.code_length > LEN_IO_W'(LEN_CAP)) ?
                         LEN_W'(LEN_CAP) : LEN_W'(cmd.code_length);

    // Decode the action; the unused code is dropped without effect.
    always_comb
    begin
        do_load   = 1'b0;
        do_encode = 1'b0;
        do_flush  = 1'b0;
        unique case (cmd.action)
            ACT_LOAD:   do_load   = accept;
            ACT_ENCODE: do_encode = accept;
            ACT_FLUSH:  do_flush  = accept;
            default:    ;
        endcase
    end

    // Hold the input while the table stage waits on the packer.
    assign cmd.ready = !s1_valid_reg || pk_ready;

    always_comb
    begin
        loaded_next = loaded_reg;
        if (do_load && in_range)
        begin
            loaded_next[sym_idx] = 1'b1;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pk_ready)
        begin
            s1_valid_next = 1'b0;
        end
        if (do_encode || do_flush)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            loaded_reg   <= loaded_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Table stage payload: advance only on an accepted encode or flush.
    always_ff @(posedge clk)
    begin
        if (do_encode || do_flush)
        begin
            s1_flush_reg <= do_flush;
            s1_hit_reg   <= do_encode && in_range && loaded_reg[sym_idx];
        end
    end

    // Table memory: write on load, registered read on encode. A load always
    // completes its write before any later encode reads, so no forwarding.
    always_ff @(posedge clk)
    begin
        if (do_load && in_range)
        begin
            table_mem[sym_idx] <= {len_clamped, cmd.code_bits[LEN_CAP-1:0]};
        end
        if (do_encode && in_range)
        begin
            rd_data_reg <= table_mem[sym_idx];
        end
    end

    // A miss (out of range or never loaded) merges as a zero-length code.
    always_comb
    begin
        pk_req.flush = s1_flush_reg;
        pk_req.code  = CODE_W'(rd_data_reg[LEN_CAP-1:0]);
        pk_req.len   = '0;
        if (s1_hit_reg && !s1_flush_reg)
        begin
            pk_req.len = LEN_IO_W'(rd_data_reg[ENTRY_W-1 -: LEN_W]);
        end
    end

    pcbp_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s1_valid_reg),
        .req_ready (pk_ready),
        .req       (pk_req),
        .res       (res)
    );

endmodule

/* rtl/core/pcbp_checker.sv */
// ----------------------------------------------------------------------------
// pcbp_checker
// Port-level checks of the packer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module pcbp_checker
    import pcbp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic [BYTE_W-1:0]  packed_byte,
    input logic [VBITS_W-1:0] valid_bits,
    input logic               last_in_run,
    input logic               is_final,
    input logic [TOTAL_W-1:0] total_bits
);

    // Hold a stalled result unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(packed_byte)
            && $stable(valid_bits) && $stable(last_in_run) && $stable(is_final))
        else $error("stalled result changed");

    // Encode bytes are always full and carry no bit count.
    a_enc_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !is_final |-> valid_bits == VBITS_W'(BYTE_W) && total_bits == '0)
        else $error("encode byte not full or carries a count");

    // A flush answer is a single partial byte closing its run.
    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_final |-> last_in_run && valid_bits < VBITS_W'(BYTE_W))
        else $error("flush answer malformed");

    // Bits below the valid ones in a flush byte are zero.
    a_final_pad: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_final |-> (packed_byte & (8'hFF >> valid_bits)) == '0)
        else $error("flush byte padding not zero");

endmodule

bind prefix_code_bit_packer_unit pcbp_checker u_pcbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .packed_byte (res.packed_byte),
    .valid_bits  (res.valid_bits),
    .last_in_run (res.last_in_run),
    .is_final    (res.is_final),
    .total_bits  (res.total_bits)
);

/* sim/tb_prefix_code_bit_packer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prefix_code_bit_packer_unit
// Self-checking bench for the table-driven prefix-code bit packer. A queue of
// load, encode and flush commands feeds a clocked driver. A predictor keeps its
// own code and length tables, byte accumulator and bit count. It builds the
// packed bytes that each accepted command must produce, and a clocked monitor
// compares every byte transfer field by field. Both sides idle at random, and
// the receiver holds off for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
module tb_prefix_code_bit_packer_unit;
    import pcbp_pkg::*;

    localparam int                  CLK_HALF     = 6;
    localparam int                  RESET_CYCLES = 12;
    localparam int                  RANDOM_ITEMS = 460;
    localparam int                  CYCLE_LIMIT  = 400000;
    localparam int                  DRAIN_CYCLES = 16;
    localparam int                  HOLD_CYCLES  = 250;
    localparam int                  REPORT_MAX   = 10;
    // Action code that the block must ignore.
    localparam logic [ACTION_W-1:0] ACT_SPARE    = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SYMBOL_W-1:0] symbol;
        logic [CODE_W-1:0]   code_bits;
        logic [LEN_IO_W-1:0] code_length;
    } cmd_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  packed_byte;
        logic [VBITS_W-1:0] valid_bits;
        logic               last_in_run;
        logic               is_final;
        logic [TOTAL_W-1:0] total_bits;
    } packed_out_t;

    logic clk;
    logic rst_n;

    pcbp_cmd_if cmd_ch ();
    pcbp_res_if res_ch ();

    prefix_code_bit_packer_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // Commands still to be offered, and bytes the block still owes us.
    cmd_item_t   pending_cmds[$];
    packed_out_t packed_q[$];

    // Shadow copy of the block's tables and packing state.
    logic [CODE_W-1:0]   sym_code [SYMBOLS_DEF];
    logic [LEN_IO_W-1:0] sym_len  [SYMBOLS_DEF];
    logic [BYTE_W-1:0]   accum_byte;
    int unsigned         accum_fill;
    logic [TOTAL_W-1:0]  bit_count;

    int          err_cnt;
    int          n_accepted;
    int unsigned cycle_cnt;
    int          send_idle;
    int          recv_idle;
    int          hold_left;
    bit          hold_early_done;
    bit          hold_late_done;
    cmd_item_t   in_flight;

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Gap length for either side: mostly none or a few cycles, now and then a
    // long one. Every fourth time window runs with no gaps at all, so
    // that back-to-back transfers get exercised too.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if ((cycle_cnt / 500) % 4 == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: apply one accepted command to the shadow state and queue the
    // packed bytes it must produce, in order.
    // ------------------------------------------------------------------------
    function automatic void pack_item(cmd_item_t item);
        packed_out_t         res;
        logic [LEN_IO_W-1:0] len;
        logic [CODE_W-1:0]   code;
        logic [TOTAL_W:0]    sum;
        int                  n_bytes;
        n_bytes = 0;
        case (item.action)
            ACT_LOAD:
            begin
                // Clamp overlong lengths to the table limit.
                len = item.code_length;
                if (len > LEN_IO_W'(MAX_CODE_LEN_DEF))
                    len = LEN_IO_W'(MAX_CODE_LEN_DEF);
                if (len > LEN_IO_W'(CODE_W))
                    len = LEN_IO_W'(CODE_W);
                sym_code[item.symbol] = item.code_bits;
                sym_len[item.symbol]  = len;
            end
            ACT_ENCODE:
            begin
                len  = sym_len[item.symbol];
                code = (len != 0) ? sym_code[item.symbol] : '0;
                // Shift code bits in, first bit first, from bit 7 downward.
                for (int i = int'(len); i > 0; i--)
                begin
                    accum_byte[7 - accum_fill] = code[i - 1];
                    accum_fill++;
                    if (accum_fill == 8)
                    begin
                        res = '{packed_byte: accum_byte, valid_bits: 4'd8,
                                last_in_run: 1'b0, is_final: 1'b0, total_bits: '0};
                        packed_q.push_back(res);
                        n_bytes++;
                        accum_byte = '0;
                        accum_fill = 0;
                    end
                end
                if (n_bytes > 0)
                    packed_q[packed_q.size() - 1].last_in_run = 1'b1;
                // Saturate the running bit count.
                sum = {1'b0, bit_count} + (TOTAL_W + 1)'(len);
                bit_count = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            end
            ACT_FLUSH:
            begin
                // Empty marker falls out naturally: zero byte, zero valid bits.
                res = '{packed_byte: accum_byte, valid_bits: VBITS_W'(accum_fill),
                        last_in_run: 1'b1, is_final: 1'b1, total_bits: bit_count};
                packed_q.push_back(res);
                accum_byte = '0;
                accum_fill = 0;
                bit_count  = '0;
            end
            default:
            begin
                // Spare action code: no result, no state change.
            end
        endcase
    endfunction

    task automatic add_cmd(logic [ACTION_W-1:0] action, logic [SYMBOL_W-1:0] symbol,
                           logic [CODE_W-1:0] code, logic [LEN_IO_W-1:0] len);
        cmd_item_t item;
        item = '{action: action, symbol: symbol, code_bits: code, code_length: len};
        pending_cmds.push_back(item);
    endtask

    // Symbols mostly come from a small working set so that encodes hit loaded
    // entries; the rest cover the whole byte range.
    function automatic logic [SYMBOL_W-1:0] pick_symbol();
        if ($urandom_range(0, 99) < 75)
            return $urandom_range(0, 1) ? SYMBOL_W'($urandom_range(0, 15))
                                        : SYMBOL_W'($urandom_range(240, 255));
        return SYMBOL_W'($urandom_range(0, 255));
    endfunction

    task automatic add_random_cmd();
        logic [ACTION_W-1:0] action;
        logic [LEN_IO_W-1:0] len;
        int                  r;
        r = $urandom_range(0, 99);
        if (r < 20)
            action = ACT_LOAD;
        else if (r < 84)
            action = ACT_ENCODE;
        else if (r < 96)
            action = ACT_FLUSH;
        else
            action = ACT_SPARE;
        // Short codes dominate, as in a real prefix code; keep some overlong.
        r = $urandom_range(0, 99);
        if (r < 50)
            len = LEN_IO_W'($urandom_range(1, 8));
        else if (r < 75)
            len = LEN_IO_W'($urandom_range(9, 32));
        else if (r < 90)
            len = LEN_IO_W'($urandom_range(33, 63));
        else
            len = '0;
        add_cmd(action, pick_symbol(), CODE_W'($urandom()), len);
    endtask

    // ------------------------------------------------------------------------
    // Driver: predict on every accepted transfer, then hold the offer, idle or
    // advance to the next queued command. One assignment per signal per edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid       <= 1'b0;
            cmd_ch.action      <= '0;
            cmd_ch.symbol      <= '0;
            cmd_ch.code_bits   <= '0;
            cmd_ch.code_length <= '0;
            send_idle = 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                pack_item(in_flight);
                n_accepted++;
            end
            // Hold the current offer until it is taken.
            if (!(cmd_ch.valid && !cmd_ch.ready))
            begin
                if (send_idle > 0)
                begin
                    send_idle--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    in_flight = pending_cmds.pop_front();
                    cmd_ch.valid       <= 1'b1;
                    cmd_ch.action      <= in_flight.action;
                    cmd_ch.symbol      <= in_flight.symbol;
                    cmd_ch.code_bits   <= in_flight.code_bits;
                    cmd_ch.code_length <= in_flight.code_length;
                    send_idle = pick_gap();
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver hold-off: twice in the run, stall the output for a long
    // stretch while the driver keeps offering, so the block fills and stalls
    // its input.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left       <= 0;
            hold_early_done <= 1'b0;
            hold_late_done  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_early_done && n_accepted >= 60)
        begin
            hold_left       <= HOLD_CYCLES;
            hold_early_done <= 1'b1;
        end
        else if (!hold_late_done && n_accepted >= 300)
        begin
            hold_left      <= HOLD_CYCLES;
            hold_late_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each byte transfer against the oldest expected byte, then
    // decide ready for the next edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        packed_out_t want;
        packed_out_t got;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            recv_idle = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got = '{packed_byte: res_ch.packed_byte, valid_bits: res_ch.valid_bits,
                        last_in_run: res_ch.last_in_run, is_final: res_ch.is_final,
                        total_bits: res_ch.total_bits};
                if (packed_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= REPORT_MAX)
                        $display("ERROR: unexpected byte %02h vbits %0d last %0b fin %0b total %0d",
                                 got.packed_byte, got.valid_bits, got.last_in_run,
                                 got.is_final, got.total_bits);
                end
                else
                begin
                    want = packed_q.pop_front();
                    if (got.packed_byte !== want.packed_byte
                        || got.valid_bits !== want.valid_bits
                        || got.last_in_run !== want.last_in_run
                        || got.is_final !== want.is_final
                        || got.total_bits !== want.total_bits)
                    begin
                        err_cnt++;
                        if (err_cnt <= REPORT_MAX)
                        begin
                            $display("ERROR: expected byte %02h vbits %0d last %0b fin %0b total %0d",
                                     want.packed_byte, want.valid_bits, want.last_in_run,
                                     want.is_final, want.total_bits);
                            $display("       got      byte %02h vbits %0d last %0b fin %0b total %0d",
                                     got.packed_byte, got.valid_bits, got.last_in_run,
                                     got.is_final, got.total_bits);
                        end
                    end
                end
                recv_idle = pick_gap();
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
            end
            else if (recv_idle > 0)
            begin
                recv_idle--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        err_cnt    = 0;
        n_accepted = 0;
        cycle_cnt  = 0;
        accum_byte = '0;
        accum_fill = 0;
        bit_count  = '0;
        for (int s = 0; s < SYMBOLS_DEF; s++)
        begin
            sym_code[s] = '0;
            sym_len[s]  = '0;
        end
        cmd_ch.valid       = 1'b0;
        cmd_ch.action      = '0;
        cmd_ch.symbol      = '0;
        cmd_ch.code_bits   = '0;
        cmd_ch.code_length = '0;
        res_ch.ready       = 1'b0;

        // Directed part: empty flush, never-loaded symbol, full-width and
        // overlong codes, zero-length and all-zero codes, byte-boundary
        // completion, partial flush, spare action code.
        add_cmd(ACT_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
        add_cmd(ACT_ENCODE, 8'd0,   32'h0000_0000, 6'd0);
        add_cmd(ACT_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd32);
        add_cmd(ACT_LOAD,   8'd255, 32'hA5A5_C3C3, 6'd63);
        add_cmd(ACT_LOAD,   8'd1,   32'h0000_0001, 6'd1);
        add_cmd(ACT_LOAD,   8'd2,   32'h0000_0000, 6'd0);
        add_cmd(ACT_LOAD,   8'd3,   32'h0000_0000, 6'd7);
        add_cmd(ACT_ENCODE, 8'd0,   32'h0000_0000, 6'd0);
        add_cmd(ACT_ENCODE, 8'd255, 32'hFFFF_FFFF, 6'd63);
        add_cmd(ACT_ENCODE, 8'd1,   32'h0000_0000, 6'd0);
        add_cmd(ACT_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
        add_cmd(ACT_FLUSH,  8'd255, 32'hFFFF_FFFF, 6'd63);
        add_cmd(ACT_ENCODE, 8'd3,   32'h0000_0000, 6'd0);
        add_cmd(ACT_ENCODE, 8'd1,   32'h0000_0000, 6'd0);
        add_cmd(ACT_ENCODE, 8'd2,   32'h0000_0000, 6'd0);
        add_cmd(ACT_SPARE,  8'd1,   32'h1234_5678, 6'd5);
        add_cmd(ACT_LOAD,   8'd4,   32'h0000_002A, 6'd40);
        add_cmd(ACT_ENCODE, 8'd4,   32'h0000_0000, 6'd0);
        add_cmd(ACT_ENCODE, 8'd3,   32'h0000_0000, 6'd0);
        add_cmd(ACT_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
        add_cmd(ACT_LOAD,   8'd0,   32'h8000_0001, 6'd33);
        add_cmd(ACT_ENCODE, 8'd0,   32'h0000_0000, 6'd0);
        add_cmd(ACT_ENCODE, 8'd0,   32'h0000_0000, 6'd0);
        add_cmd(ACT_FLUSH,  8'd0,   32'h0000_0000, 6'd0);

        // Random part: seed the working set with codes first, then mix.
        for (int s = 0; s < 8; s++)
            add_cmd(ACT_LOAD, pick_symbol(), CODE_W'($urandom()),
                    LEN_IO_W'($urandom_range(1, 12)));
        for (int k = 0; k < RANDOM_ITEMS; k++)
            add_random_cmd();
        add_cmd(ACT_FLUSH, 8'd0, 32'h0000_0000, 6'd0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n = 1'b1;

        // Drain: wait for the last command and its last byte, then idle a bit
        // longer to catch stray bytes.
        while (pending_cmds.size() > 0 || cmd_ch.valid || packed_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* prefix_code_bit_packer_unit.f */
rtl/core/pcbp_pkg.sv
rtl/core/pcbp_cmd_if.sv
rtl/core/pcbp_res_if.sv
rtl/core/pcbp_packer.sv
rtl/core/prefix_code_bit_packer_unit.sv
rtl/core/pcbp_checker.sv
sim/tb_prefix_code_bit_packer_unit.sv
